/* sv/gamepad_poll_responder_top_assert.svh */
// Assertion macros for the gamepad poll responder checker.
`ifndef GAMEPAD_POLL_RESPONDER_TOP_ASSERT_SVH
`define GAMEPAD_POLL_RESPONDER_TOP_ASSERT_SVH

// Clocked check, masked while reset is high.
`define GPR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gamepad poll responder check failed");

// Clocked check that also covers the reset cycles.
`define GPR_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("gamepad poll responder check failed");

`endif

/* sv/gpr_pkg.sv */
// Shared types and constants for the gamepad poll responder.
package gpr_pkg;

   localparam logic [7:0] CMD_IDENT     = 8'h00;
   localparam logic [7:0] CMD_RESET     = 8'hFF;
   localparam logic [7:0] CMD_POLL      = 8'h40;
   localparam logic [7:0] CMD_ORIGIN    = 8'h41;
   localparam logic [7:0] CMD_CALIBRATE = 8'h42;
   localparam logic [7:0] CMD_POLL_LONG = 8'h43;

   localparam logic [7:0] PACK_MODE1 = 8'd1;
   localparam logic [7:0] PACK_MODE2 = 8'd2;
   localparam logic [7:0] PACK_MODE3 = 8'd3;
   localparam logic [7:0] PACK_MODE4 = 8'd4;

   localparam logic REG_RUMBLE_EN   = 1'b0;
   localparam logic REG_TRIG_THRESH = 1'b1;

   localparam logic [7:0] TRIG_THRESH_RESET = 8'h30;
   localparam logic [7:0] HI_NIBBLE         = 8'hF0;
   localparam logic [7:0] BTN_TRIG_R        = 8'h20;
   localparam logic [7:0] BTN_TRIG_L        = 8'h40;

   localparam int unsigned REPLY_MAX = 10;

   localparam logic [3:0] LEN_NONE  = 4'd0;
   localparam logic [3:0] LEN_IDENT = 4'd3;
   localparam logic [3:0] LEN_POLL  = 4'd8;
   localparam logic [3:0] LEN_LONG  = 4'd10;

   localparam logic [2:0][7:0] IDENT_BYTES = {8'h20, 8'h00, 8'h09};
   localparam logic [REPLY_MAX-1:0][7:0] NEUTRAL_BYTES =
      {8'h00, 8'h00, 8'h20, 8'h20, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00};

   typedef struct packed {
      logic [REPLY_MAX-1:0][7:0] data;
      logic [3:0]                len;
      logic                      clear_origin;
      logic                      rumble_changed;
      logic                      rumble_on;
   } reply_type;

   typedef struct packed {
      logic [1:0] left_cnt;
      logic [1:0] right_cnt;
      logic       rumble;
   } port_state_type;

endpackage

/* sv/gpr_reply_build.sv */
// Builds the full reply and the next port state for one command.
module gpr_reply_build
   import gpr_pkg::*;
(
   input  logic           port_ok,
   input  logic [7:0]     command,
   input  logic [7:0]     mode_byte,
   input  logic           rumble_req,
   input  logic [15:0]    buttons,
   input  logic [15:0]    button_keep_mask,
   input  logic [47:0]    axes,
   input  logic [47:0]    axis_overrides,
   input  logic           rumble_en,
   input  logic [7:0]     trigger_threshold,
   input  port_state_type cur_state,
   output reply_type      reply,
   output logic           state_we,
   output port_state_type next_state
);

   logic [5:0][7:0] axis_raw;
   logic [5:0][7:0] axis_ovr;
   logic [5:0][7:0] axis_val;
   logic [5:0][7:0] axis_pack;
   logic [15:0]     btn;
   logic [7:0]      btn_hi;
   logic            is_poll;

   assign axis_raw = axes;
   assign axis_ovr = axis_overrides;
   assign btn      = buttons & button_keep_mask;

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         axis_val[i] = (axis_ovr[i] != 8'h00) ? axis_ovr[i] : axis_raw[i];
      end
   end

   // digital trigger bits stay masked until two polls in a row are above threshold
   always_comb begin
      btn_hi = btn[15:8];
      if (cur_state.right_cnt < 2'd2) begin
         btn_hi = btn_hi & ~BTN_TRIG_R;
      end
      if (cur_state.left_cnt < 2'd2) begin
         btn_hi = btn_hi & ~BTN_TRIG_L;
      end
   end

   always_comb begin
      axis_pack = axis_val;
      if (command != CMD_POLL_LONG) begin
         unique case (mode_byte)
            PACK_MODE1: begin
               axis_pack[2] = (axis_val[2] & HI_NIBBLE) | (axis_val[3] >> 4);
               axis_pack[3] = axis_val[4];
               axis_pack[4] = axis_val[5];
               axis_pack[5] = 8'h00;
            end
            PACK_MODE2: begin
               axis_pack[2] = (axis_val[2] & HI_NIBBLE) | (axis_val[3] >> 4);
               axis_pack[3] = (axis_val[4] & HI_NIBBLE) | (axis_val[5] >> 4);
               axis_pack[4] = 8'h00;
               axis_pack[5] = 8'h00;
            end
            PACK_MODE3: begin
               axis_pack = axis_val;
            end
            PACK_MODE4: begin
               axis_pack[4] = 8'h00;
               axis_pack[5] = 8'h00;
            end
            default: begin
               axis_pack[4] = (axis_val[4] & HI_NIBBLE) | (axis_val[5] >> 4);
               axis_pack[5] = 8'h00;
            end
         endcase
      end
   end

   always_comb begin
      reply   = '0;
      is_poll = 1'b0;
      if (port_ok) begin
         unique case (command)
            CMD_IDENT, CMD_RESET: begin
               reply.data[2:0] = IDENT_BYTES;
               reply.len       = LEN_IDENT;
            end
            CMD_ORIGIN, CMD_CALIBRATE: begin
               reply.data         = NEUTRAL_BYTES;
               reply.len          = LEN_LONG;
               reply.clear_origin = 1'b1;
            end
            CMD_POLL, CMD_POLL_LONG: begin
               is_poll         = 1'b1;
               reply.data[0]   = btn[7:0];
               reply.data[1]   = btn_hi;
               reply.data[7:2] = axis_pack;
               reply.len       = (command == CMD_POLL_LONG) ? LEN_LONG : LEN_POLL;
               reply.rumble_changed = rumble_en && (cur_state.rumble != rumble_req);
               reply.rumble_on      = rumble_en && (cur_state.rumble != rumble_req)
                                      && rumble_req;
            end
            default: begin
               reply = '0;
            end
         endcase
      end
   end

   // trigger counts saturate at two; rumble state follows the request on enabled ports
   always_comb begin
      next_state = cur_state;
      if (axis_val[4] > trigger_threshold) begin
         if (cur_state.left_cnt < 2'd2) begin
            next_state.left_cnt = cur_state.left_cnt + 2'd1;
         end
      end else begin
         next_state.left_cnt = 2'd0;
      end
      if (axis_val[5] > trigger_threshold) begin
         if (cur_state.right_cnt < 2'd2) begin
            next_state.right_cnt = cur_state.right_cnt + 2'd1;
         end
      end else begin
         next_state.right_cnt = 2'd0;
      end
      if (rumble_en) begin
         next_state.rumble = rumble_req;
      end
   end

   assign state_we = is_poll;

endmodule

/* sv/gamepad_poll_responder_top.sv */
// Top level of the gamepad poll responder.
//
// Input channel (req_*): one received command per transaction with the port
// number and the live pad state. Result channel (rsp_*): one reply byte per
// transaction, in send order, with rsp_last_byte on the final byte of a reply.
// Configuration (csr_*): write-only registers, index 0 rumble enable per port,
// index 1 trigger threshold; write only while no reply is pending.
// The command is registered in the input register and then in the reply
// buffer, which drives the reply bytes. A reply streams one byte per cycle
// while rsp_stall is low: 3 bytes for identity, 8 for a short poll, 10 for a
// long poll or origin command. The input register holds the next command while
// the reply buffer drains, so a command is taken every cycle until the buffer
// is busy; the buffer takes a new reply only as its last byte leaves.
// Commands with no reply, or for a port beyond NUM_PORTS, are dropped.
// Reset clears all trigger counts, rumble states, both registers to their
// defaults and empties the pipeline. A stall on rsp holds the current byte;
// req_stall rises once the held command cannot move into the reply buffer.
module gamepad_poll_responder_top
   import gpr_pkg::*;
#(
   parameter int NUM_PORTS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_port,
   input  logic [7:0]  req_command,
   input  logic [7:0]  req_mode_byte,
   input  logic [7:0]  req_rumble_byte,
   input  logic [15:0] req_buttons,
   input  logic [15:0] req_button_keep_mask,
   input  logic [47:0] req_axes,
   input  logic [47:0] req_axis_overrides,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_response_byte,
   output logic        rsp_last_byte,
   output logic        rsp_clear_origin,
   output logic        rsp_rumble_changed,
   output logic        rsp_rumble_on,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   // the port field reaches four ports at most
   localparam int NumLive = (NUM_PORTS < 4) ? NUM_PORTS : 4;

   logic [3:0]     rumble_en_ff;
   logic [7:0]     trig_thresh_ff;
   port_state_type port_state_ff [NumLive];

   logic           s1_valid_ff;
   logic [1:0]     s1_port_ff;
   logic [7:0]     s1_command_ff;
   logic [7:0]     s1_mode_ff;
   logic           s1_rumble_ff;
   logic [15:0]    s1_buttons_ff;
   logic [15:0]    s1_keep_ff;
   logic [47:0]    s1_axes_ff;
   logic [47:0]    s1_ovr_ff;

   logic           buf_valid_ff;
   logic           buf_valid_in;
   reply_type      buf_ff;
   logic [3:0]     idx_ff;
   logic [3:0]     idx_in;

   logic           port_ok;
   port_state_type cur_state;
   port_state_type next_state;
   logic           state_we;
   reply_type      reply;
   logic           buf_last;
   logic           buf_done;
   logic           buf_free;
   logic           s1_adv;
   logic           req_take;

   assign port_ok = 3'(s1_port_ff) < 3'(NumLive);

   always_comb begin
      cur_state = '0;
      for (int p = 0; p < NumLive; p++) begin
         if (s1_port_ff == 2'(p)) begin
            cur_state = port_state_ff[p];
         end
      end
   end

   gpr_reply_build u_build (
      .port_ok           (port_ok),
      .command           (s1_command_ff),
      .mode_byte         (s1_mode_ff),
      .rumble_req        (s1_rumble_ff),
      .buttons           (s1_buttons_ff),
      .button_keep_mask  (s1_keep_ff),
      .axes              (s1_axes_ff),
      .axis_overrides    (s1_ovr_ff),
      .rumble_en         (rumble_en_ff[s1_port_ff]),
      .trigger_threshold (trig_thresh_ff),
      .cur_state         (cur_state),
      .reply             (reply),
      .state_we          (state_we),
      .next_state        (next_state)
   );

   assign buf_last = (idx_ff == buf_ff.len - 4'd1);
   assign buf_done = buf_valid_ff && !rsp_stall && buf_last;
   assign buf_free = !buf_valid_ff || buf_done;
   // a command with no reply drops straight through
   assign s1_adv   = s1_valid_ff && ((reply.len == LEN_NONE) || buf_free);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      buf_valid_in = buf_valid_ff;
      idx_in       = idx_ff;
      if (buf_valid_ff && !rsp_stall) begin
         idx_in = idx_ff + 4'd1;
         if (buf_last) begin
            buf_valid_in = 1'b0;
         end
      end
      if (s1_adv && (reply.len != LEN_NONE)) begin
         buf_valid_in = 1'b1;
         idx_in       = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rumble_en_ff   <= '0;
         trig_thresh_ff <= TRIG_THRESH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_RUMBLE_EN:   rumble_en_ff   <= csr_wdata[3:0];
            REG_TRIG_THRESH: trig_thresh_ff <= csr_wdata;
            default:         rumble_en_ff   <= rumble_en_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int p = 0; p < NumLive; p++) begin
         if (reset) begin
            port_state_ff[p] <= '0;
         end else if (s1_adv && state_we && (s1_port_ff == 2'(p))) begin
            port_state_ff[p] <= next_state;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_port_ff    <= req_port;
         s1_command_ff <= req_command;
         s1_mode_ff    <= req_mode_byte;
         s1_rumble_ff  <= req_rumble_byte[0];
         s1_buttons_ff <= req_buttons;
         s1_keep_ff    <= req_button_keep_mask;
         s1_axes_ff    <= req_axes;
         s1_ovr_ff     <= req_axis_overrides;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         buf_valid_ff <= buf_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && (reply.len != LEN_NONE)) begin
         buf_ff <= reply;
      end
   end

   assign rsp_valid          = buf_valid_ff;
   assign rsp_response_byte  = buf_ff.data[idx_ff];
   assign rsp_last_byte      = buf_last;
   assign rsp_clear_origin   = buf_ff.clear_origin;
   assign rsp_rumble_changed = buf_ff.rumble_changed;
   assign rsp_rumble_on      = buf_ff.rumble_on;

endmodule

/* sv/gpr_checker.sv */
// Port-level checker for the gamepad poll responder, bound to the top level.
`include "gamepad_poll_responder_top_assert.svh"

module gpr_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_response_byte,
   input logic       rsp_last_byte,
   input logic       rsp_clear_origin,
   input logic       rsp_rumble_changed,
   input logic       rsp_rumble_on
);

   `GPR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_response_byte) && $stable(rsp_last_byte))
   `GPR_ASSERT(a_flags_exclusive, clock, reset, rsp_valid |-> !(rsp_clear_origin && rsp_rumble_changed))
   `GPR_ASSERT(a_rumble_on_needs_change, clock, reset, rsp_valid && rsp_rumble_on |-> rsp_rumble_changed)
   `GPR_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind gamepad_poll_responder_top gpr_checker u_gpr_checker (.*);
